// File: rtl/core/boundary_tag_first_fit_allocator_unit_assert.svh
// assertion macros for the allocator rtl
// depends on nothing; included by btffa_ctrl to check its own control logic
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_UNIT_ASSERT_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BTFFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// next-cycle implication
`define BTFFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// File: rtl/core/btffa_pkg.sv
// shared constants, command and status types of the boundary tag allocator
// used by btffa_dpath, btffa_ctrl and the top level
package btffa_pkg;

	localparam int unsigned HEAP_WORDS   = 4096;
	localparam int unsigned WORD_BYTES   = 8;
	localparam int unsigned WORD_SHIFT   = $clog2(WORD_BYTES);
	localparam int unsigned BYTE_ADDR_W  = 32;
	localparam int unsigned REQ_W        = 16;
	localparam int unsigned ADDR_W       = $clog2(HEAP_WORDS);
	localparam int unsigned SIZE_W       = $clog2(HEAP_WORDS + 1);
	localparam int unsigned SUM_W        = SIZE_W + 1;
	localparam int unsigned TAG_W        = SIZE_W + 1;
	localparam int unsigned NEED_W       = REQ_W - WORD_SHIFT + 1;
	localparam int unsigned CMP_W        = ((NEED_W > SIZE_W) ? NEED_W : SIZE_W) + 1;
	localparam int unsigned WORD_IDX_W   = BYTE_ADDR_W - WORD_SHIFT;
	localparam int unsigned TAG_OVERHEAD = 2;
	localparam int unsigned MIN_SPLIT    = 3;

	typedef enum logic [2:0] {
		RA_P,
		RA_STEP,
		RA_HTAIL,
		RA_NEXT,
		RA_PREV,
		RA_QHEAD,
		RA_QNEXT
	} rd_sel_t;

	typedef enum logic [1:0] {
		WA_HEAD,
		WA_TAIL,
		WA_INIT0,
		WA_INITN
	} wr_sel_t;

	typedef enum logic [3:0] {
		LD_NONE,
		LD_INPUT,
		LD_STEP,
		LD_FIT,
		LD_REST,
		LD_HDR,
		LD_FREE,
		LD_GROW,
		LD_PREV,
		LD_QHDR
	} ld_sel_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_FAIL,
		RES_ALLOC_OK,
		RES_FREE_OK
	} res_sel_t;

	typedef struct packed {
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     wr_en;
		wr_sel_t  wr_sel;
		ld_sel_t  ld;
		res_sel_t res;
	} dp_cmd_t;

	typedef struct packed {
		logic is_free;
		logic fbad;
		logic a_bad;
		logic a_fit;
		logic a_split;
		logic a_end;
		logic h_bad;
		logic t_match;
		logic nx_in;
		logic merge;
		logic p_zero;
		logic p_ok;
		logic q_ok;
	} dp_sts_t;

endpackage

// File: rtl/core/btffa_dpath.sv
// datapath: tag memory, walk and block registers, base register, result word
// depends on btffa_pkg; driven by btffa_ctrl through dp_cmd_t
module btffa_dpath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	input  logic [btffa_pkg::BYTE_ADDR_W-1:0]       cfg_data,
	input  logic                                    opcode,
	input  logic [btffa_pkg::REQ_W-1:0]             request_bytes,
	input  logic [btffa_pkg::BYTE_ADDR_W-1:0]       free_address,
	input  btffa_pkg::dp_cmd_t                      cmd,
	output btffa_pkg::dp_sts_t                      sts,
	output logic [btffa_pkg::BYTE_ADDR_W-1:0]       payload_address,
	output logic                                    success
);

	localparam int unsigned AW  = btffa_pkg::ADDR_W;
	localparam int unsigned SW  = btffa_pkg::SIZE_W;
	localparam int unsigned UW  = btffa_pkg::SUM_W;
	localparam int unsigned TW  = btffa_pkg::TAG_W;
	localparam int unsigned NW  = btffa_pkg::NEED_W;
	localparam int unsigned CW  = btffa_pkg::CMP_W;
	localparam int unsigned BW  = btffa_pkg::BYTE_ADDR_W;
	localparam int unsigned WS  = btffa_pkg::WORD_SHIFT;
	localparam int unsigned IW  = btffa_pkg::WORD_IDX_W;
	localparam int unsigned RW  = btffa_pkg::REQ_W;
	localparam logic [UW-1:0] HEAP_END = UW'(btffa_pkg::HEAP_WORDS);

	logic [TW-1:0] mem [btffa_pkg::HEAP_WORDS];

	logic [BW-1:0] base_q;
	logic [TW-1:0] rdata_q;
	logic          is_free_q;
	logic          fbad_q;
	logic [NW-1:0] need_q;
	logic [AW-1:0] p_q;
	logic [TW-1:0] t_q;
	logic [AW-1:0] blk_p_q;
	logic [SW-1:0] blk_len_q;
	logic          blk_used_q;
	logic [BW-1:0] payload_address_q;
	logic          success_q;

	logic [SW-1:0] rsize;
	logic          rused;
	logic [UW-1:0] sum_ps;
	logic [UW-1:0] blk_end;
	logic [UW-1:0] blk_sum;
	logic [UW-1:0] q_sum;
	logic [CW-1:0] left;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [TW-1:0] wdata;
	logic [BW-1:0] off;
	logic [IW-1:0] word_idx;
	logic          in_fbad;
	logic [NW-1:0] in_need;
	logic [SW-1:0] p_plus1;
	logic [BW-1:0] alloc_addr;

	assign rsize   = rdata_q[TW-1:1];
	assign rused   = rdata_q[0];
	assign sum_ps  = UW'(p_q) + UW'(rsize);
	assign blk_end = UW'(blk_p_q) + UW'(blk_len_q);
	assign blk_sum = blk_end + UW'(rsize);
	assign q_sum   = UW'(blk_p_q) + UW'(rsize);
	assign left    = CW'(rsize) - CW'(need_q);

	assign off      = free_address - base_q;
	assign word_idx = off[BW-1:WS];
	assign in_fbad  = (|off[WS-1:0]) || (word_idx == '0) ||
		(word_idx > IW'(btffa_pkg::HEAP_WORDS));
	assign in_need  = NW'(request_bytes[RW-1:WS]) + NW'(|request_bytes[WS-1:0]) +
		NW'(btffa_pkg::TAG_OVERHEAD);

	assign p_plus1    = SW'(p_q) + SW'(1);
	assign alloc_addr = base_q + BW'({p_plus1, {WS{1'b0}}});

	always_comb begin
		sts.is_free = is_free_q;
		sts.fbad    = fbad_q;
		sts.a_bad   = (rsize == '0) || (sum_ps > HEAP_END);
		sts.a_fit   = !rused && (CW'(rsize) >= CW'(need_q));
		sts.a_split = left >= CW'(btffa_pkg::MIN_SPLIT);
		sts.a_end   = sum_ps >= HEAP_END;
		sts.h_bad   = (rsize < SW'(btffa_pkg::TAG_OVERHEAD)) || (sum_ps > HEAP_END);
		sts.t_match = rdata_q == t_q;
		sts.nx_in   = blk_end < HEAP_END;
		sts.merge   = (rsize != '0) && (blk_sum <= HEAP_END) && !blk_used_q && !rused;
		sts.p_zero  = p_q == '0;
		sts.p_ok    = (rsize != '0) && (UW'(rsize) <= UW'(p_q));
		sts.q_ok    = (rsize != '0) && (q_sum < HEAP_END);
	end

	always_comb begin
		unique case (cmd.rd_sel)
			btffa_pkg::RA_P:     raddr = p_q;
			btffa_pkg::RA_STEP:  raddr = AW'(sum_ps);
			btffa_pkg::RA_HTAIL: raddr = AW'(sum_ps - UW'(1));
			btffa_pkg::RA_NEXT:  raddr = AW'(blk_end);
			btffa_pkg::RA_PREV:  raddr = p_q - AW'(1);
			btffa_pkg::RA_QHEAD: raddr = AW'(UW'(p_q) - UW'(rsize));
			btffa_pkg::RA_QNEXT: raddr = AW'(q_sum);
			default:             raddr = p_q;
		endcase
	end

	always_comb begin
		unique case (cmd.wr_sel)
			btffa_pkg::WA_HEAD: begin
				waddr = blk_p_q;
				wdata = {blk_len_q, blk_used_q};
			end
			btffa_pkg::WA_TAIL: begin
				waddr = AW'(blk_end - UW'(1));
				wdata = {blk_len_q, blk_used_q};
			end
			btffa_pkg::WA_INIT0: begin
				waddr = '0;
				wdata = {SW'(btffa_pkg::HEAP_WORDS), 1'b0};
			end
			btffa_pkg::WA_INITN: begin
				waddr = AW'(btffa_pkg::HEAP_WORDS - 1);
				wdata = {SW'(btffa_pkg::HEAP_WORDS), 1'b0};
			end
			default: begin
				waddr = blk_p_q;
				wdata = {blk_len_q, blk_used_q};
			end
		endcase
	end

	// tag memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_valid) begin
			base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.ld)
			btffa_pkg::LD_NONE: begin
			end
			btffa_pkg::LD_INPUT: begin
				is_free_q <= opcode;
				fbad_q    <= in_fbad;
				need_q    <= in_need;
				p_q       <= opcode ? AW'(word_idx - IW'(1)) : '0;
			end
			btffa_pkg::LD_STEP: begin
				p_q <= AW'(sum_ps);
			end
			btffa_pkg::LD_FIT: begin
				blk_p_q    <= p_q;
				blk_len_q  <= sts.a_split ? SW'(need_q) : rsize;
				blk_used_q <= 1'b1;
			end
			btffa_pkg::LD_REST: begin
				blk_p_q    <= AW'(UW'(p_q) + UW'(need_q));
				blk_len_q  <= SW'(left);
				blk_used_q <= 1'b0;
			end
			btffa_pkg::LD_HDR: begin
				t_q <= rdata_q;
			end
			btffa_pkg::LD_FREE: begin
				blk_p_q    <= p_q;
				blk_len_q  <= t_q[TW-1:1];
				blk_used_q <= 1'b0;
			end
			btffa_pkg::LD_GROW: begin
				blk_len_q <= SW'(UW'(blk_len_q) + UW'(rsize));
			end
			btffa_pkg::LD_PREV: begin
				blk_p_q <= AW'(UW'(p_q) - UW'(rsize));
			end
			btffa_pkg::LD_QHDR: begin
				blk_len_q  <= rsize;
				blk_used_q <= rused;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (cmd.res)
			btffa_pkg::RES_NONE: begin
			end
			btffa_pkg::RES_FAIL: begin
				payload_address_q <= '0;
				success_q         <= 1'b0;
			end
			btffa_pkg::RES_ALLOC_OK: begin
				payload_address_q <= alloc_addr;
				success_q         <= 1'b1;
			end
			btffa_pkg::RES_FREE_OK: begin
				payload_address_q <= '0;
				success_q         <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign payload_address = payload_address_q;
	assign success         = success_q;

endmodule

// File: rtl/core/btffa_ctrl.sv
// controller: sequences tag reads and writes for allocate and free words
// depends on btffa_pkg and boundary_tag_first_fit_allocator_unit_assert.svh
`include "boundary_tag_first_fit_allocator_unit_assert.svh"

module btffa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  btffa_pkg::dp_sts_t  sts,
	output btffa_pkg::dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_INIT0,
		ST_INIT1,
		ST_IDLE,
		ST_CHK,
		ST_A_EV,
		ST_A_WH,
		ST_A_WT,
		ST_A_RH,
		ST_A_RT,
		ST_F_H,
		ST_F_T,
		ST_F_WH,
		ST_F_WT,
		ST_F_N,
		ST_F_NH,
		ST_F_NT,
		ST_F_PV,
		ST_F_P,
		ST_F_Q,
		ST_F_QN,
		ST_F_QH,
		ST_F_QT,
		ST_DONE
	} state_t;

	state_t               state_q, state_d;
	btffa_pkg::res_sel_t  res_q, res_d;
	logic                 out_valid_q;
	logic                 out_free;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		res_d   = res_q;
		unique case (state_q)
			ST_INIT0: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = btffa_pkg::WA_INIT0;
				state_d    = ST_INIT1;
			end
			ST_INIT1: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = btffa_pkg::WA_INITN;
				state_d    = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.ld  = btffa_pkg::LD_INPUT;
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (sts.is_free && sts.fbad) begin
					res_d   = btffa_pkg::RES_FAIL;
					state_d = ST_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = btffa_pkg::RA_P;
					state_d    = sts.is_free ? ST_F_H : ST_A_EV;
				end
			end
			ST_A_EV: begin
				priority if (sts.a_bad) begin
					res_d   = btffa_pkg::RES_FAIL;
					state_d = ST_DONE;
				end else if (sts.a_fit) begin
					cmd.ld  = btffa_pkg::LD_FIT;
					state_d = ST_A_WH;
				end else if (sts.a_end) begin
					res_d   = btffa_pkg::RES_FAIL;
					state_d = ST_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = btffa_pkg::RA_STEP;
					cmd.ld     = btffa_pkg::LD_STEP;
				end
			end
			ST_A_WH: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = btffa_pkg::WA_HEAD;
				state_d    = ST_A_WT;
			end
			ST_A_WT: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = btffa_pkg::WA_TAIL;
				if (sts.a_split) begin
					cmd.ld  = btffa_pkg::LD_REST;
					state_d = ST_A_RH;
				end else begin
					res_d   = btffa_pkg::RES_ALLOC_OK;
					state_d = ST_DONE;
				end
			end
			ST_A_RH: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = btffa_pkg::WA_HEAD;
				state_d    = ST_A_RT;
			end
			ST_A_RT: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = btffa_pkg::WA_TAIL;
				res_d      = btffa_pkg::RES_ALLOC_OK;
				state_d    = ST_DONE;
			end
			ST_F_H: begin
				if (sts.h_bad) begin
					res_d   = btffa_pkg::RES_FAIL;
					state_d = ST_DONE;
				end else begin
					cmd.ld     = btffa_pkg::LD_HDR;
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = btffa_pkg::RA_HTAIL;
					state_d    = ST_F_T;
				end
			end
			ST_F_T: begin
				if (!sts.t_match) begin
					res_d   = btffa_pkg::RES_FAIL;
					state_d = ST_DONE;
				end else begin
					cmd.ld  = btffa_pkg::LD_FREE;
					state_d = ST_F_WH;
				end
			end
			ST_F_WH: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = btffa_pkg::WA_HEAD;
				state_d    = ST_F_WT;
			end
			ST_F_WT: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = btffa_pkg::WA_TAIL;
				if (sts.nx_in) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = btffa_pkg::RA_NEXT;
					state_d    = ST_F_N;
				end else begin
					state_d = ST_F_PV;
				end
			end
			ST_F_N: begin
				if (sts.merge) begin
					cmd.ld  = btffa_pkg::LD_GROW;
					state_d = ST_F_NH;
				end else begin
					state_d = ST_F_PV;
				end
			end
			ST_F_NH: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = btffa_pkg::WA_HEAD;
				state_d    = ST_F_NT;
			end
			ST_F_NT: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = btffa_pkg::WA_TAIL;
				state_d    = ST_F_PV;
			end
			ST_F_PV: begin
				if (sts.p_zero) begin
					res_d   = btffa_pkg::RES_FREE_OK;
					state_d = ST_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = btffa_pkg::RA_PREV;
					state_d    = ST_F_P;
				end
			end
			ST_F_P: begin
				if (sts.p_ok) begin
					cmd.ld     = btffa_pkg::LD_PREV;
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = btffa_pkg::RA_QHEAD;
					state_d    = ST_F_Q;
				end else begin
					res_d   = btffa_pkg::RES_FREE_OK;
					state_d = ST_DONE;
				end
			end
			ST_F_Q: begin
				if (sts.q_ok) begin
					cmd.ld     = btffa_pkg::LD_QHDR;
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = btffa_pkg::RA_QNEXT;
					state_d    = ST_F_QN;
				end else begin
					res_d   = btffa_pkg::RES_FREE_OK;
					state_d = ST_DONE;
				end
			end
			ST_F_QN: begin
				if (sts.merge) begin
					cmd.ld  = btffa_pkg::LD_GROW;
					state_d = ST_F_QH;
				end else begin
					res_d   = btffa_pkg::RES_FREE_OK;
					state_d = ST_DONE;
				end
			end
			ST_F_QH: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = btffa_pkg::WA_HEAD;
				state_d    = ST_F_QT;
			end
			ST_F_QT: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = btffa_pkg::WA_TAIL;
				res_d      = btffa_pkg::RES_FREE_OK;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.res = res_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT0;
			res_q       <= btffa_pkg::RES_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (cmd.res != btffa_pkg::RES_NONE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`BTFFA_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.res != btffa_pkg::RES_NONE, out_free)
	`BTFFA_ASSERT_NEXT(a_res_shows, clk, arst_n, cmd.res != btffa_pkg::RES_NONE, out_valid)
	`BTFFA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`BTFFA_ASSERT_NOW(a_idle_no_write, clk, arst_n, in_ready, !cmd.wr_en)

endmodule

// File: rtl/core/boundary_tag_first_fit_allocator_unit.sv
// top level of the boundary tag first fit heap allocator
// depends on btffa_pkg, btffa_ctrl and btffa_dpath
//
// usage:
//   in channel (in_valid/in_ready): opcode 0 allocates request_bytes, opcode 1
//   frees the block whose payload starts at free_address.
//   out channel (out_valid/out_ready): one word per input word, payload_address
//   and success.
//   cfg channel (cfg_valid/cfg_ready): writes heap_base from cfg_data; always
//   ready. Write it only while no word is in flight; the block does not enforce it.
// throughput:
//   one word at a time, set by the tag memory walking the heap.
//   allocate: walks the blocks from the first, then writes 2 or 4 tags on success.
//   free: checks the header and trailer tags, then merges with free neighbors.
//   the result sits in an output register, so in_ready returns while it waits.
// reset:
//   the init states write the header and trailer of one free block spanning
//   the whole heap; in_ready stays low until it is done.
// stall:
//   a held result blocks only the finish of the next word, not its acceptance.
module boundary_tag_first_fit_allocator_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [btffa_pkg::BYTE_ADDR_W-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic [btffa_pkg::REQ_W-1:0]       request_bytes,
	input  logic [btffa_pkg::BYTE_ADDR_W-1:0] free_address,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [btffa_pkg::BYTE_ADDR_W-1:0] payload_address,
	output logic                              success
);

	btffa_pkg::dp_cmd_t cmd;
	btffa_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	btffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	btffa_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.opcode          (opcode),
		.request_bytes   (request_bytes),
		.free_address    (free_address),
		.cmd             (cmd),
		.sts             (sts),
		.payload_address (payload_address),
		.success         (success)
	);

endmodule
